// File: hw/rtl/rfdsq_pkg.sv
// Shared types, constants and helpers for the ready FIFO and delta sleep queue.
package rfdsq_pkg;

  localparam int MAX_THREADS = 64;
  localparam int SLOT_W      = $clog2(MAX_THREADS);
  localparam int PTR_W       = SLOT_W + 1;
  localparam int CNT_W       = PTR_W;
  localparam int TICK_W      = 32;
  localparam int REQ_W       = 2;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t                 NIL         = PTR_W'(MAX_THREADS);
  localparam logic [CNT_W-1:0]     MAX_CNT     = CNT_W'(MAX_THREADS);
  localparam logic [SLOT_W-1:0]    IDLE_RESET  = SLOT_W'(MAX_THREADS - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_SLEEP = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  function automatic logic slot_ok(input ptr_t p);
    return p < NIL;
  endfunction

endpackage

// File: hw/rtl/rfdsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rfdsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ready_fifo_and_delta_sleep_queue.sv
// Top level of the thread scheduler: ready FIFO and delta-ordered sleep list.
//
//   channel  direction  handshake              beat contents
//   cfg      in         cfg_valid / cfg_ready  cfg_data (idle thread slot)
//   in       in         in_valid / in_ready    req_type, thread_id, sleep_ticks
//   out      out        out_valid / out_ready  next_thread, is_idle, status, woken_count
//
// Enqueue visits S_LINK only when the ready queue is non-empty; dequeue visits S_DEQ unless empty.
// Sleep walks the sleep list in S_WALK, up to MAX_THREADS entries, then splices in via S_SFIN.
// A tick repeats S_TCHK per woken thread, with S_LINK when it joins a non-empty ready queue.
// Synchronous reset empties all lists; the RAMs are not cleared and need no sweep.
// A new request beat is taken while the previous result still waits on the output register.
// A finished result stalls in place only when the output register is still occupied.
module ready_fifo_and_delta_sleep_queue import rfdsq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SLOT_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [SLOT_W-1:0] thread_id,
  input  logic [TICK_W-1:0] sleep_ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] next_thread,
  output logic              is_idle,
  output logic              status,
  output logic [CNT_W-1:0]  woken_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LINK,
    S_DEQ,
    S_WALK,
    S_SFIN,
    S_TCHK,
    S_RESP
  } state_t;

  state_t            state;
  req_t              op;
  logic [SLOT_W-1:0] idle_thread;
  ptr_t              ready_head;
  ptr_t              ready_tail;
  ptr_t              sleep_head;
  ptr_t              prev;
  ptr_t              curr;
  ptr_t              tail_save;
  logic [SLOT_W-1:0] sid;
  logic [TICK_W-1:0] ticks;
  logic [TICK_W-1:0] dcur;
  logic [CNT_W-1:0]  steps;
  logic [CNT_W-1:0]  woken;
  logic              first;
  logic [SLOT_W-1:0] res_nt;
  logic              res_idle;
  logic              res_status;

  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  ptr_t              link_wdata;
  ptr_t              link_rdata;
  logic              delta_we;
  logic [SLOT_W-1:0] delta_waddr;
  logic [TICK_W-1:0] delta_wdata;
  logic [TICK_W-1:0] delta_rdata;
  logic [SLOT_W-1:0] rd_addr;

  logic              link_fwd_hit;
  ptr_t              link_fwd_data;
  logic              delta_fwd_hit;
  logic [TICK_W-1:0] delta_fwd_data;

  ptr_t              link_q;
  logic [TICK_W-1:0] delta_q;
  ptr_t              link_nh;
  logic [TICK_W-1:0] dval;
  logic              accept;
  logic              wake;
  logic              walk_cont;
  logic              ready_empty;
  logic              tid_idle;
  logic              head_idle;

  rfdsq_ram #(.WIDTH(PTR_W), .DEPTH(MAX_THREADS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  rfdsq_ram #(.WIDTH(TICK_W), .DEPTH(MAX_THREADS)) u_delta_ram (
    .clk   (clk),
    .we    (delta_we),
    .waddr (delta_waddr),
    .wdata (delta_wdata),
    .raddr (rd_addr),
    .rdata (delta_rdata)
  );

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign link_q      = link_fwd_hit ? link_fwd_data : link_rdata;
  assign delta_q     = delta_fwd_hit ? delta_fwd_data : delta_rdata;
  assign link_nh     = slot_ok(link_q) ? link_q : NIL;
  assign dval        = first ? (delta_q - TICK_W'(1)) : delta_q;
  assign wake        = slot_ok(sleep_head) && (dval == '0) && (steps < MAX_CNT);
  assign walk_cont   = slot_ok(curr) && (steps < MAX_CNT) && (ticks > delta_q);
  assign ready_empty = !slot_ok(ready_head) || !slot_ok(ready_tail);
  assign tid_idle    = (thread_id == idle_thread);
  assign head_idle   = (sleep_head[SLOT_W-1:0] == idle_thread);

  always_comb begin
    link_we     = 1'b0;
    link_waddr  = sid;
    link_wdata  = NIL;
    delta_we    = 1'b0;
    delta_waddr = sid;
    delta_wdata = ticks;
    rd_addr     = sleep_head[SLOT_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_ENQ && !tid_idle) begin
          link_we    = 1'b1;
          link_waddr = thread_id;
        end
        if (req_type == REQ_DEQ) begin
          rd_addr = ready_head[SLOT_W-1:0];
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = tail_save[SLOT_W-1:0];
        link_wdata = PTR_W'(sid);
      end
      S_DEQ: begin
        link_we    = 1'b1;
        link_waddr = ready_head[SLOT_W-1:0];
      end
      S_WALK: begin
        if (walk_cont) begin
          rd_addr = link_q[SLOT_W-1:0];
        end else begin
          link_we    = slot_ok(prev);
          link_waddr = prev[SLOT_W-1:0];
          link_wdata = PTR_W'(sid);
          delta_we   = 1'b1;
        end
      end
      S_SFIN: begin
        link_we     = 1'b1;
        link_wdata  = curr;
        delta_we    = slot_ok(curr) && (curr != PTR_W'(sid));
        delta_waddr = curr[SLOT_W-1:0];
        delta_wdata = dcur - ticks;
      end
      S_TCHK: begin
        delta_we    = first;
        delta_waddr = sleep_head[SLOT_W-1:0];
        delta_wdata = dval;
        if (wake) begin
          link_we    = 1'b1;
          link_waddr = sleep_head[SLOT_W-1:0];
          rd_addr    = link_nh[SLOT_W-1:0];
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idle_thread   <= IDLE_RESET;
      ready_head    <= NIL;
      ready_tail    <= NIL;
      sleep_head    <= NIL;
      out_valid     <= 1'b0;
      link_fwd_hit  <= 1'b0;
      delta_fwd_hit <= 1'b0;
      steps         <= '0;
      woken         <= '0;
    end else begin
      link_fwd_hit   <= link_we && (link_waddr == rd_addr);
      link_fwd_data  <= link_wdata;
      delta_fwd_hit  <= delta_we && (delta_waddr == rd_addr);
      delta_fwd_data <= delta_wdata;
      if (cfg_valid) begin
        idle_thread <= cfg_data;
      end
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req_t'(req_type);
            sid        <= thread_id;
            res_nt     <= '0;
            res_idle   <= 1'b0;
            res_status <= 1'b0;
            woken      <= '0;
            steps      <= '0;
            first      <= 1'b1;
            ticks      <= sleep_ticks;
            prev       <= NIL;
            curr       <= sleep_head;
            unique case (req_t'(req_type))
              REQ_ENQ: begin
                if (tid_idle) begin
                  res_status <= 1'b1;
                  state      <= S_RESP;
                end else begin
                  ready_tail <= PTR_W'(thread_id);
                  if (ready_empty) begin
                    ready_head <= PTR_W'(thread_id);
                    state      <= S_RESP;
                  end else begin
                    tail_save <= ready_tail;
                    state     <= S_LINK;
                  end
                end
              end
              REQ_DEQ: begin
                if (!slot_ok(ready_head)) begin
                  res_nt   <= idle_thread;
                  res_idle <= 1'b1;
                  state    <= S_RESP;
                end else begin
                  state <= S_DEQ;
                end
              end
              REQ_SLEEP: begin
                if (sleep_ticks == '0) begin
                  res_status <= 1'b1;
                  state      <= S_RESP;
                end else begin
                  state <= S_WALK;
                end
              end
              REQ_TICK: begin
                state <= slot_ok(sleep_head) ? S_TCHK : S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_LINK: begin
          state <= (op == REQ_TICK) ? S_TCHK : S_RESP;
        end
        S_DEQ: begin
          res_nt     <= ready_head[SLOT_W-1:0];
          ready_head <= link_nh;
          if (!slot_ok(link_q)) begin
            ready_tail <= NIL;
          end
          state <= S_RESP;
        end
        S_WALK: begin
          if (walk_cont) begin
            ticks <= ticks - delta_q;
            prev  <= curr;
            curr  <= link_q;
            steps <= steps + CNT_W'(1);
          end else begin
            if (!slot_ok(curr)) begin
              curr <= NIL;
            end
            if (!slot_ok(prev)) begin
              sleep_head <= PTR_W'(sid);
            end
            dcur  <= delta_q;
            state <= S_SFIN;
          end
        end
        S_SFIN: begin
          state <= S_RESP;
        end
        S_TCHK: begin
          first <= 1'b0;
          if (wake) begin
            sleep_head <= link_nh;
            steps      <= steps + CNT_W'(1);
            sid        <= sleep_head[SLOT_W-1:0];
            if (!head_idle) begin
              woken      <= woken + CNT_W'(1);
              ready_tail <= sleep_head;
              if (ready_empty) begin
                ready_head <= sleep_head;
              end else begin
                tail_save <= ready_tail;
                state     <= S_LINK;
              end
            end
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            next_thread <= res_nt;
            is_idle     <= res_idle;
            status      <= res_status;
            woken_count <= woken;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_ends_agree: assert property (@(posedge clk) disable iff (rst)
    slot_ok(ready_head) == slot_ok(ready_tail))
    else $error("ready queue head and tail disagree on emptiness");

  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    steps <= MAX_CNT)
    else $error("list walk ran past the slot count");

  a_woken_le_steps: assert property (@(posedge clk) disable iff (rst)
    woken <= steps)
    else $error("more threads woken than sleep entries visited");

  a_resp_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result was not loaded into the output register");
`endif

endmodule
